// ===== rtl/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BCD_W  = 4;
  localparam int unsigned CHAR_W = 7;

  localparam logic [BCD_W-1:0]  DABBLE_MIN  = 4'd5;
  localparam logic [BCD_W-1:0]  BCD_TEN     = 4'd10;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== rtl/sbda_cell.sv =====
// ----------------------------------------------------------------------------
// sbda_cell
// One BCD digit of the double dabble chain: clears, doubles its digit with carry in,
// or takes the digit of its lower neighbor when the string is shifted out.
// ----------------------------------------------------------------------------
module sbda_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sbda_pkg::cell_ctrl_t         ctrl_i,
  input  logic                         carry_i,
  input  logic [sbda_pkg::BCD_W-1:0]   digit_i,
  output logic                         carry_o,
  output logic [sbda_pkg::BCD_W-1:0]   digit_o
);
  import sbda_pkg::*;

  logic [BCD_W-1:0] digit_q, digit_d;
  logic [BCD_W-1:0] dbl;
  logic             ge5;

  assign ge5     = (digit_q >= DABBLE_MIN);
  assign dbl     = {digit_q[BCD_W-2:0], carry_i};
  assign carry_o = ge5;
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = ge5 ? (dbl - BCD_TEN) : dbl;
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

// ===== rtl/signed_128bit_to_decimal_ascii.sv =====
// Sequence: WORD_COUNT requests to load, then a prepare step, a dabble pass over
// the value MSB first, an optional sign character, a zero-skip phase, then one
// character per cycle; busy_o stays high from the last load request to the last char.
// A new value is taken only after the last character of the previous one; the
// conversion is bit-serial through the digit cell chain.
// Reset: asynchronous, clears control and digits; results cannot be stalled.
// ----------------------------------------------------------------------------
// signed_128bit_to_decimal_ascii
// Collects a signed multiword value, converts it to BCD by double dabble in a
// chain of digit cells and emits sign and digits in ASCII, the digits one char a cycle.
// ----------------------------------------------------------------------------
module signed_128bit_to_decimal_ascii #(
  parameter int unsigned WORD_COUNT  = 4,
  parameter int unsigned DIGIT_COUNT = 39
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [sbda_pkg::WORD_W-1:0]   word_value_i,
  output logic                          strobe_o,
  output logic [sbda_pkg::CHAR_W-1:0]   char_code_o,
  output logic                          last_char_o
);
  import sbda_pkg::*;

  localparam int unsigned VW   = WORD_W * WORD_COUNT;
  localparam int unsigned WIDX = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned BW   = $clog2(VW);
  localparam int unsigned DW   = $clog2(DIGIT_COUNT + 1);

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_PREP = 6'b000010,
    S_CONV = 6'b000100,
    S_SIGN = 6'b001000,
    S_SKIP = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [WIDX-1:0]   wc_q, wc_d;
  logic [BW-1:0]     bit_q, bit_d;
  logic [DW-1:0]     dig_q, dig_d;
  logic              neg_q, neg_d;
  logic [VW-1:0]     mag_q, mag_d;
  logic [WORD_W-1:0] ws_q [WORD_COUNT];
  logic [VW-1:0]     val;
  logic              accept;
  cell_ctrl_t        ctrl;
  logic [BCD_W-1:0]  top_digit;

  logic [DIGIT_COUNT:0]  carry;
  logic [BCD_W-1:0]      digit [DIGIT_COUNT+1];

  assign busy_o = (state_q != S_LOAD);
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ws_q[wc_q] <= word_value_i;
    end
  end

  always_comb begin
    for (int w = 0; w < WORD_COUNT; w++) begin
      val[VW-1-WORD_W*w -: WORD_W] = ws_q[w];
    end
  end

  assign carry[0] = mag_q[VW-1];
  assign digit[0] = '0;

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
    sbda_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .carry_i (carry[g]),
      .digit_i (digit[g]),
      .carry_o (carry[g+1]),
      .digit_o (digit[g+1])
    );
  end

  assign top_digit = digit[DIGIT_COUNT];

  always_comb begin
    state_d     = state_q;
    wc_d        = wc_q;
    bit_d       = bit_q;
    dig_d       = dig_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    ctrl        = '0;
    strobe_o    = 1'b0;
    char_code_o = ASCII_ZERO + CHAR_W'(top_digit);
    last_char_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (wc_q == WIDX'(WORD_COUNT - 1)) begin
            wc_d    = '0;
            state_d = S_PREP;
          end else begin
            wc_d = wc_q + 1'b1;
          end
        end
      end
      S_PREP: begin
        neg_d      = ws_q[0][WORD_W-1];
        mag_d      = ws_q[0][WORD_W-1] ? (~val + 1'b1) : val;
        bit_d      = BW'(VW - 1);
        ctrl.clear = 1'b1;
        state_d    = S_CONV;
      end
      S_CONV: begin
        ctrl.dabble = 1'b1;
        mag_d       = {mag_q[VW-2:0], 1'b0};
        bit_d       = bit_q - 1'b1;
        if (bit_q == '0) begin
          dig_d   = DW'(DIGIT_COUNT);
          state_d = neg_q ? S_SIGN : S_SKIP;
        end
      end
      S_SIGN: begin
        strobe_o    = 1'b1;
        char_code_o = ASCII_MINUS;
        state_d     = S_SKIP;
      end
      S_SKIP: begin
        if (top_digit == '0 && dig_q > DW'(1)) begin
          ctrl.shift = 1'b1;
          dig_d      = dig_q - 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        strobe_o    = 1'b1;
        last_char_o = (dig_q == DW'(1));
        ctrl.shift  = 1'b1;
        dig_d       = dig_q - 1'b1;
        if (dig_q == DW'(1)) begin
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      wc_q    <= '0;
      bit_q   <= '0;
      dig_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      wc_q    <= wc_d;
      bit_q   <= bit_d;
      dig_q   <= dig_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

endmodule

// ===== test/tb_signed_128bit_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_128bit_to_decimal_ascii
// Loads signed 128-bit values as four words each and checks every emitted
// ASCII character against a double dabble predictor or a typed-in string.
// A directed table covers zero, one, minus one, both extremes and 2**64-1;
// random values follow in phases with and without request gaps.
// ----------------------------------------------------------------------------
module tb_signed_128bit_to_decimal_ascii;
  import sbda_pkg::*;

  localparam int unsigned WORDS   = 4;
  localparam int unsigned DIGITS  = 39;
  localparam int unsigned VALUE_W = WORDS * WORD_W;
  localparam int unsigned RANDOM_VALUES = 32;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    string              text;
  } value_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic [WORD_W-1:0]   word_value_i = '0;
  logic                busy_o;
  logic                strobe_o;
  logic [CHAR_W-1:0]   char_code_o;
  logic                last_char_o;

  ascii_char_t         pending_chars[$];
  logic [VALUE_W-1:0]  held_value = '0;
  int unsigned         words_held = 0;
  int unsigned         error_count = 0;
  int unsigned         chars_seen = 0;
  int unsigned         values_sent = 0;

  signed_128bit_to_decimal_ascii #(
    .WORD_COUNT (WORDS),
    .DIGIT_COUNT(DIGITS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .word_value_i(word_value_i),
    .strobe_o    (strobe_o),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void predict_chars(input logic [VALUE_W-1:0] value);
    logic             neg;
    logic [VALUE_W-1:0] mag;
    logic [BCD_W-1:0] digs [DIGITS];
    logic             carry;
    logic [BCD_W:0]   twice;
    int               top;
    neg = value[VALUE_W-1];
    mag = neg ? (~value + 1'b1) : value;
    foreach (digs[d]) digs[d] = '0;
    for (int b = VALUE_W - 1; b >= 0; b--) begin
      carry = mag[b];
      for (int d = 0; d < DIGITS; d++) begin
        twice = {digs[d], 1'b0} + carry;
        if (digs[d] >= DABBLE_MIN) begin
          digs[d] = BCD_W'(twice - BCD_TEN);
          carry = 1'b1;
        end else begin
          digs[d] = twice[BCD_W-1:0];
          carry = 1'b0;
        end
      end
    end
    top = DIGITS - 1;
    while (top > 0 && digs[top] == '0) top--;
    if (neg) pending_chars.push_back('{code: ASCII_MINUS, last: 1'b0});
    for (int d = top; d >= 0; d--)
      pending_chars.push_back('{code: ASCII_ZERO + digs[d], last: (d == 0)});
  endfunction

  function automatic void push_text(input string text);
    byte ch;
    for (int i = 0; i < text.len(); i++) begin
      ch = text[i];
      pending_chars.push_back('{code: ch[CHAR_W-1:0], last: (i == text.len() - 1)});
    end
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w, input int unsigned idle_pct,
                           input string text);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    word_value_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    held_value = {held_value[VALUE_W-WORD_W-1:0], w};
    words_held++;
    if (words_held == WORDS) begin
      words_held = 0;
      values_sent++;
      if (text != "") push_text(text);
      else predict_chars(held_value);
    end
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] value, input int unsigned idle_pct,
                            input string text);
    for (int i = 0; i < WORDS; i++)
      send_word(value[VALUE_W-1-WORD_W*i -: WORD_W], idle_pct, text);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(4))
      0: ;
      1: v = {{(VALUE_W-WORD_W){1'b0}}, v[WORD_W-1:0]};
      2: v = {{(VALUE_W-WORD_W){1'b1}}, v[WORD_W-1:0]};
      3: begin
        v = v >> $urandom_range(VALUE_W - 1);
        if ($urandom_range(1)) v = -v;
      end
      default: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = '1;
          2: v = {1'b0, {(VALUE_W-1){1'b1}}};
          3: v = {1'b1, {(VALUE_W-1){1'b0}}};
          default: v = {{(VALUE_W-1){1'b0}}, 1'b1} << $urandom_range(VALUE_W - 1);
        endcase
      end
    endcase
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        $error("unexpected char_code %0d last_char %0d", char_code_o, last_char_o);
        error_count++;
      end else begin
        if (char_code_o !== pending_chars[0].code) begin
          $error("char_code expected %0d actual %0d", pending_chars[0].code, char_code_o);
          error_count++;
        end
        if (last_char_o !== pending_chars[0].last) begin
          $error("last_char expected %0d actual %0d", pending_chars[0].last, last_char_o);
          error_count++;
        end
        void'(pending_chars.pop_front());
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    value_row_t  rows [6];
    int unsigned idle_by_phase [4];
    int unsigned phase;
    rows[0] = '{value: '0, text: "0"};
    rows[1] = '{value: 128'd1, text: "1"};
    rows[2] = '{value: '1, text: "-1"};
    rows[3] = '{value: {1'b0, {(VALUE_W-1){1'b1}}},
                text: "170141183460469231731687303715884105727"};
    rows[4] = '{value: {1'b1, {(VALUE_W-1){1'b0}}},
                text: "-170141183460469231731687303715884105728"};
    rows[5] = '{value: 128'h0000_0000_0000_0000_FFFF_FFFF_FFFF_FFFF, text: ""};
    idle_by_phase = '{0, 60, 0, 25};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_value(rows[i].value, 0, rows[i].text);

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      phase = (i * 4) / RANDOM_VALUES;
      send_value(random_value(), idle_by_phase[phase], "");
    end
    start_i <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      $error("%0d expected chars never arrived", pending_chars.size());
      error_count++;
    end

    $display("converted %0d values (directed extremes and random), %0d chars checked",
             values_sent, chars_seen);
    $display("request gaps exercised at 0, 25 and 60 percent");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
